### hdl/assert_macros.svh
// Assertion macros used by the back end RTL of the pointer motion scaler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PMS_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pms: assertion failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PMS_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pms: assertion failed");

`endif

### hdl/pms_pkg.sv
// Package of types, codes and ratio tables for the pointer motion scaler.
package pms_pkg;

  localparam int MOUSE_LEVELS_DEF  = 7;
  localparam int SCROLL_LEVELS_DEF = 8;
  localparam int QUEUE_DEPTH       = 2;
  localparam int RECIP_SHIFT       = 20;
  localparam int RECIP_W           = RECIP_SHIFT + 1;

  localparam logic [2:0] KIND_REL_X  = 3'd0;
  localparam logic [2:0] KIND_REL_Y  = 3'd1;
  localparam logic [2:0] KIND_HWHEEL = 3'd2;
  localparam logic [2:0] KIND_WHEEL  = 3'd3;

  localparam logic [2:0] ACT_INV_WHEEL   = 3'd0;
  localparam logic [2:0] ACT_INV_HWHEEL  = 3'd1;
  localparam logic [2:0] ACT_MOUSE_UP    = 3'd2;
  localparam logic [2:0] ACT_MOUSE_DOWN  = 3'd3;
  localparam logic [2:0] ACT_SCROLL_UP   = 3'd4;
  localparam logic [2:0] ACT_SCROLL_DOWN = 3'd5;

  typedef enum logic [1:0] {
    OP_SCALE,
    OP_PASS,
    OP_CLR_MOUSE,
    OP_CLR_SCROLL
  } pms_op_t;

  typedef struct packed {
    logic [2:0] mul;
    logic [4:0] div;
  } pms_ratio_t;

  typedef struct packed {
    pms_op_t            op;
    logic [1:0]         axis;
    logic signed [15:0] value;
    logic               sync;
    pms_ratio_t         ratio;
    logic               invert;
  } pms_cmd_t;

  typedef struct packed {
    logic     valid;
    pms_cmd_t cmd;
  } pms_push_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL,
    B_RECIP,
    B_FIX,
    B_DONE
  } pms_bstate_t;

  function automatic pms_ratio_t pms_mouse_ratio(input logic [2:0] lvl);
    pms_ratio_t r;
    case (lvl)
      3'd0:    r = '{mul: 3'd1, div: 5'd2};
      3'd1:    r = '{mul: 3'd3, div: 5'd4};
      3'd2:    r = '{mul: 3'd1, div: 5'd1};
      3'd3:    r = '{mul: 3'd5, div: 5'd4};
      3'd4:    r = '{mul: 3'd3, div: 5'd2};
      3'd5:    r = '{mul: 3'd7, div: 5'd4};
      default: r = '{mul: 3'd2, div: 5'd1};
    endcase
    return r;
  endfunction

  function automatic pms_ratio_t pms_scroll_ratio(input logic [2:0] lvl);
    pms_ratio_t r;
    case (lvl)
      3'd0:    r = '{mul: 3'd1, div: 5'd4};
      3'd1:    r = '{mul: 3'd1, div: 5'd3};
      3'd2:    r = '{mul: 3'd7, div: 5'd20};
      3'd3:    r = '{mul: 3'd2, div: 5'd5};
      3'd4:    r = '{mul: 3'd1, div: 5'd2};
      3'd5:    r = '{mul: 3'd1, div: 5'd1};
      3'd6:    r = '{mul: 3'd2, div: 5'd1};
      default: r = '{mul: 3'd3, div: 5'd1};
    endcase
    return r;
  endfunction

  // Reciprocal floor(2^RECIP_SHIFT / div) for every divisor in the tables.
  function automatic logic [RECIP_W-1:0] pms_recip(input logic [4:0] div);
    logic [RECIP_W-1:0] r;
    case (div)
      5'd1:    r = RECIP_W'(64'd1 << RECIP_SHIFT);
      5'd2:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 2);
      5'd3:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 3);
      5'd4:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 4);
      5'd5:    r = RECIP_W'((64'd1 << RECIP_SHIFT) / 5);
      5'd20:   r = RECIP_W'((64'd1 << RECIP_SHIFT) / 20);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### hdl/pms_in_if.sv
// Input channel interface: motion events and control actions.
interface pms_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic [2:0]         event_kind;
  logic signed [15:0] motion_value;
  logic               sync_flag;
  logic [2:0]         action;

  modport source (output valid, func, event_kind, motion_value, sync_flag, action,
                  input ready);
  modport sink (input valid, func, event_kind, motion_value, sync_flag, action,
                output ready);
endinterface

### hdl/pms_out_if.sv
// Output channel interface: scaled values with their keep flag.
interface pms_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] scaled_value;
  logic               keep_event;

  modport source (output valid, scaled_value, keep_event, input ready);
  modport sink (input valid, scaled_value, keep_event, output ready);
endinterface

### hdl/pms_front.sv
// Front end: accepts transactions, keeps levels and inversion, issues commands.
module pms_front #(
  parameter int MOUSE_LEVELS  = pms_pkg::MOUSE_LEVELS_DEF,
  parameter int SCROLL_LEVELS = pms_pkg::SCROLL_LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  pms_in_if.sink            events,
  input  logic              full,
  output pms_pkg::pms_push_t push
);
  import pms_pkg::*;

  localparam logic [2:0] MouseTop    = 3'(MOUSE_LEVELS - 1);
  localparam logic [2:0] ScrollTop   = 3'(SCROLL_LEVELS - 1);
  localparam logic [2:0] MouseReset  = (MouseTop < 3'd4) ? MouseTop : 3'd4;
  localparam logic [2:0] ScrollReset = (ScrollTop < 3'd2) ? ScrollTop : 3'd2;

  logic [2:0] mouse_level, mouse_level_next;
  logic [2:0] scroll_level, scroll_level_next;
  logic       invert_horizontal, invert_horizontal_next;
  logic       invert_vertical, invert_vertical_next;
  logic       accept;

  assign events.ready = !full;
  assign accept       = events.valid && !full;

  always_comb begin
    mouse_level_next       = mouse_level;
    scroll_level_next      = scroll_level;
    invert_horizontal_next = invert_horizontal;
    invert_vertical_next   = invert_vertical;
    push.valid             = 1'b0;
    push.cmd.op            = OP_PASS;
    push.cmd.axis          = events.event_kind[1:0];
    push.cmd.value         = events.motion_value;
    push.cmd.sync          = events.sync_flag;
    push.cmd.ratio         = pms_mouse_ratio(mouse_level);
    push.cmd.invert        = 1'b0;
    if (accept && events.func) begin
      unique case (events.action)
        ACT_INV_WHEEL: begin
          invert_vertical_next = !invert_vertical;
        end
        ACT_INV_HWHEEL: begin
          invert_horizontal_next = !invert_horizontal;
        end
        ACT_MOUSE_UP: begin
          if (mouse_level < MouseTop) mouse_level_next = mouse_level + 3'd1;
          push.valid  = 1'b1;
          push.cmd.op = OP_CLR_MOUSE;
        end
        ACT_MOUSE_DOWN: begin
          if (mouse_level != 3'd0) mouse_level_next = mouse_level - 3'd1;
          push.valid  = 1'b1;
          push.cmd.op = OP_CLR_MOUSE;
        end
        ACT_SCROLL_UP: begin
          if (scroll_level < ScrollTop) scroll_level_next = scroll_level + 3'd1;
          push.valid  = 1'b1;
          push.cmd.op = OP_CLR_SCROLL;
        end
        ACT_SCROLL_DOWN: begin
          if (scroll_level != 3'd0) scroll_level_next = scroll_level - 3'd1;
          push.valid  = 1'b1;
          push.cmd.op = OP_CLR_SCROLL;
        end
        default: ;
      endcase
    end else if (accept) begin
      push.valid = 1'b1;
      unique case (events.event_kind) inside
        KIND_REL_X, KIND_REL_Y: begin
          push.cmd.op = OP_SCALE;
        end
        KIND_HWHEEL: begin
          push.cmd.op     = OP_SCALE;
          push.cmd.ratio  = pms_scroll_ratio(scroll_level);
          push.cmd.invert = invert_horizontal;
        end
        KIND_WHEEL: begin
          push.cmd.op     = OP_SCALE;
          push.cmd.ratio  = pms_scroll_ratio(scroll_level);
          push.cmd.invert = invert_vertical;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mouse_level       <= MouseReset;
      scroll_level      <= ScrollReset;
      invert_horizontal <= 1'b0;
      invert_vertical   <= 1'b0;
    end else begin
      mouse_level       <= mouse_level_next;
      scroll_level      <= scroll_level_next;
      invert_horizontal <= invert_horizontal_next;
      invert_vertical   <= invert_vertical_next;
    end
  end

endmodule

### hdl/pms_queue.sv
// Short command queue between the front end and the arithmetic back end.
module pms_queue (
  input  logic               clk,
  input  logic               rst,
  input  pms_pkg::pms_push_t push,
  output logic               full,
  output logic               pop_valid,
  input  logic               pop_ready,
  output pms_pkg::pms_cmd_t  pop_cmd
);
  import pms_pkg::*;

  localparam int Depth = QUEUE_DEPTH;
  localparam int PtrW  = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  pms_cmd_t        slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign full      = (count == CntW'(Depth));
  assign pop_valid = (count != '0);
  assign pop_cmd   = slots[rd_ptr];
  assign do_push   = push.valid && !full;
  assign do_pop    = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push.cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

### hdl/pms_back.sv
// Back end: remainder store, reciprocal divider sequence and output register.
`include "assert_macros.svh"

module pms_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  pms_pkg::pms_cmd_t pop_cmd,
  pms_out_if.source         results
);
  import pms_pkg::*;

  pms_bstate_t        state, state_next;
  pms_cmd_t           cur;
  logic signed [5:0]  rem [4];
  logic [17:0]        n_mag, q_mag;
  logic               n_neg;
  logic               out_valid, out_keep;
  logic signed [15:0] out_value;

  logic               out_free, take, load_out;
  logic signed [18:0] n_val;
  logic [RECIP_W+17:0] recip_prod;
  logic [17:0]        q_est;
  logic [22:0]        qd;
  logic [17:0]        r_est;
  logic [17:0]        q_fix;
  logic [4:0]         r_fix;
  logic signed [18:0] q_s;
  logic signed [15:0] res_sat, res;
  logic               res_keep;

  assign out_free      = !out_valid || results.ready;
  assign results.valid = out_valid;
  assign results.scaled_value = out_value;
  assign results.keep_event   = out_keep;

  // The next command is taken from an idle sequencer or as a result leaves.
  assign take      = pop_valid && ((state == B_IDLE) || (state == B_DONE && out_free));
  assign pop_ready = take;
  assign load_out  = (state == B_DONE) && out_free;

  always_comb begin
    n_val = 19'(cur.value) * 19'(signed'({1'b0, cur.ratio.mul})) + 19'(rem[cur.axis]);
  end

  // The reciprocal estimate is at most one below the true quotient.
  assign recip_prod = (RECIP_W + 18)'(n_mag) * (RECIP_W + 18)'(pms_recip(cur.ratio.div));
  assign q_est      = 18'(recip_prod >> RECIP_SHIFT);

  always_comb begin
    qd    = 23'(q_mag) * 23'(cur.ratio.div);
    r_est = n_mag - 18'(qd);
    if (r_est >= 18'(cur.ratio.div)) begin
      q_fix = q_mag + 18'd1;
      r_fix = 5'(r_est - 18'(cur.ratio.div));
    end else begin
      q_fix = q_mag;
      r_fix = 5'(r_est);
    end
  end

  always_comb begin
    q_s = n_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    if (q_s > 19'sd32767)       res_sat = 16'sh7fff;
    else if (q_s < -19'sd32768) res_sat = -16'sh8000;
    else                        res_sat = 16'(q_s);
    if (cur.op == OP_PASS) res_sat = cur.value;
    if (!cur.invert)                res = res_sat;
    else if (res_sat == -16'sh8000) res = 16'sh7fff;
    else                            res = -res_sat;
    res_keep = (cur.op == OP_PASS) || cur.sync || (res != 16'sd0);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE:  state_next = B_IDLE;
      B_MUL:   state_next = B_RECIP;
      B_RECIP: state_next = B_FIX;
      B_FIX:   state_next = B_DONE;
      B_DONE:  if (out_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
    if (take) begin
      unique case (pop_cmd.op)
        OP_SCALE: state_next = B_MUL;
        OP_PASS:  state_next = B_DONE;
        default:  state_next = B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (take) cur <= pop_cmd;
    if (state == B_MUL) begin
      n_neg <= n_val[18];
      n_mag <= 18'(n_val[18] ? -n_val : n_val);
    end
    if (state == B_RECIP) q_mag <= q_est;
    if (state == B_FIX)   q_mag <= q_fix;
    if (load_out) begin
      out_value <= res;
      out_keep  <= res_keep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      rem[0]    <= '0;
      rem[1]    <= '0;
      rem[2]    <= '0;
      rem[3]    <= '0;
    end else begin
      if (load_out)           out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
      // The remainder keeps the sign of the dividend.
      if (state == B_FIX) begin
        rem[cur.axis] <= n_neg ? -$signed({1'b0, r_fix}) : $signed({1'b0, r_fix});
      end
      if (take && pop_cmd.op == OP_CLR_MOUSE) begin
        rem[0] <= '0;
        rem[1] <= '0;
      end
      if (take && pop_cmd.op == OP_CLR_SCROLL) begin
        rem[2] <= '0;
        rem[3] <= '0;
      end
    end
  end

  `PMS_ASSERT_IMP(a_est_not_above, state == B_FIX, 18'(qd) <= n_mag)
  `PMS_ASSERT_IMP(a_rem_below_div, state == B_FIX, r_fix < cur.ratio.div)
  `PMS_ASSERT_NXT(a_rem_stored, state == B_FIX, rem[cur.axis] < 6'sd20 && rem[cur.axis] > -6'sd20)

endmodule

### hdl/pointer_motion_scaler_unit.sv
// Pointer motion scaler: a rational scale with carried remainders on four axes,
// ahead of a command queue. An event passes the arithmetic back end in the steps
// sum and magnitude, reciprocal multiply, quotient correction and remainder
// write-back, and output; the remainder loop of that sequencer holds it to one
// event at a time, so the next event is taken only as the last result enters the
// output register. A control action is absorbed by the front end; level steps also
// place a remainder-clear command in the two-entry queue, which the back end
// retires without a result. The front end keeps accepting while the queue has
// room, and a held result in the output register does not stop it.
module pointer_motion_scaler_unit #(
  parameter int MOUSE_LEVELS  = pms_pkg::MOUSE_LEVELS_DEF,
  parameter int SCROLL_LEVELS = pms_pkg::SCROLL_LEVELS_DEF
) (
  input logic       clk,
  input logic       rst,
  pms_in_if.sink    events,
  pms_out_if.source results
);
  import pms_pkg::*;

  pms_push_t push;
  pms_cmd_t  pop_cmd;
  logic      full, pop_valid, pop_ready;

  pms_front #(
    .MOUSE_LEVELS  (MOUSE_LEVELS),
    .SCROLL_LEVELS (SCROLL_LEVELS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .events (events),
    .full   (full),
    .push   (push)
  );

  pms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd)
  );

  pms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .results   (results)
  );

endmodule

### bench/pms_checker.sv
`timescale 1ns / 1ps
// Checker for the pointer motion scaler: tracks scaler state, predicts each event and compares.
module pms_checker (
  input  logic clk,
  input  logic rst,
  pms_in_if    events,
  pms_out_if   results,
  output int   fail_count,
  output int   pending
);
  import pms_pkg::*;

  localparam int MOUSE_TOP  = MOUSE_LEVELS_DEF - 1;
  localparam int SCROLL_TOP = SCROLL_LEVELS_DEF - 1;

  typedef struct {
    logic signed [15:0] value;
    logic               keep;
  } scaled_event_t;

  scaled_event_t scaled_q[$];

  int   mouse_lvl;
  int   scroll_lvl;
  logic inv_h;
  logic inv_v;
  int   axis_carry[4];

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    fail_count++;
  endtask

  function automatic logic signed [15:0] clamp16(input int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic void pick_ratio(input logic scroll, input int lvl,
                                     output int mul, output int div);
    if (!scroll) begin
      case (lvl)
        0: begin mul = 1; div = 2; end
        1: begin mul = 3; div = 4; end
        2: begin mul = 1; div = 1; end
        3: begin mul = 5; div = 4; end
        4: begin mul = 3; div = 2; end
        5: begin mul = 7; div = 4; end
        default: begin mul = 2; div = 1; end
      endcase
    end else begin
      case (lvl)
        0: begin mul = 1; div = 4; end
        1: begin mul = 1; div = 3; end
        2: begin mul = 7; div = 20; end
        3: begin mul = 2; div = 5; end
        4: begin mul = 1; div = 2; end
        5: begin mul = 1; div = 1; end
        6: begin mul = 2; div = 1; end
        default: begin mul = 3; div = 1; end
      endcase
    end
  endfunction

  // The carry is taken from the unsaturated quotient; SV division truncates toward zero.
  function automatic int scale_axis(input int axis, input int v, input int mul, input int div);
    int n;
    int q;
    n = v * mul + axis_carry[axis];
    q = n / div;
    axis_carry[axis] = n - q * div;
    return q;
  endfunction

  function automatic scaled_event_t scale_event(input logic [2:0] kind,
                                                input logic signed [15:0] value,
                                                input logic sync);
    int mul;
    int div;
    int v;
    scaled_event_t r;
    v = int'(value);
    case (kind) inside
      KIND_REL_X, KIND_REL_Y: begin
        pick_ratio(1'b0, mouse_lvl, mul, div);
        v = clamp16(scale_axis(int'(kind), v, mul, div));
      end
      KIND_HWHEEL: begin
        pick_ratio(1'b1, scroll_lvl, mul, div);
        v = clamp16(scale_axis(int'(KIND_HWHEEL), v, mul, div));
        if (inv_h) v = clamp16(-v);
      end
      KIND_WHEEL: begin
        pick_ratio(1'b1, scroll_lvl, mul, div);
        v = clamp16(scale_axis(int'(KIND_WHEEL), v, mul, div));
        if (inv_v) v = clamp16(-v);
      end
      default: ;
    endcase
    r.value = v[15:0];
    r.keep  = (v != 0) || sync || (kind > KIND_WHEEL);
    return r;
  endfunction

  // Level steps saturate at the table ends but clear the group's carries regardless.
  task automatic apply_control(input logic [2:0] act);
    case (act)
      ACT_INV_WHEEL:  inv_v = !inv_v;
      ACT_INV_HWHEEL: inv_h = !inv_h;
      ACT_MOUSE_UP: begin
        if (mouse_lvl < MOUSE_TOP) mouse_lvl++;
        axis_carry[KIND_REL_X] = 0;
        axis_carry[KIND_REL_Y] = 0;
      end
      ACT_MOUSE_DOWN: begin
        if (mouse_lvl > 0) mouse_lvl--;
        axis_carry[KIND_REL_X] = 0;
        axis_carry[KIND_REL_Y] = 0;
      end
      ACT_SCROLL_UP: begin
        if (scroll_lvl < SCROLL_TOP) scroll_lvl++;
        axis_carry[KIND_HWHEEL] = 0;
        axis_carry[KIND_WHEEL]  = 0;
      end
      ACT_SCROLL_DOWN: begin
        if (scroll_lvl > 0) scroll_lvl--;
        axis_carry[KIND_HWHEEL] = 0;
        axis_carry[KIND_WHEEL]  = 0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    scaled_event_t want;
    if (rst) begin
      mouse_lvl  = (4 > MOUSE_TOP) ? MOUSE_TOP : 4;
      scroll_lvl = (2 > SCROLL_TOP) ? SCROLL_TOP : 2;
      inv_h      = 1'b0;
      inv_v      = 1'b0;
      foreach (axis_carry[i]) axis_carry[i] = 0;
      scaled_q.delete();
      fail_count = 0;
    end else begin
      if (results.valid && results.ready) begin
        if (scaled_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0b with nothing expected",
                                    results.scaled_value, results.keep_event));
        end else begin
          want = scaled_q.pop_front();
          if (results.scaled_value !== want.value)
            report_mismatch($sformatf("scaled_value %0d, expected %0d",
                                      results.scaled_value, want.value));
          if (results.keep_event !== want.keep)
            report_mismatch($sformatf("keep_event %b, expected %b",
                                      results.keep_event, want.keep));
        end
      end
      if (events.valid && events.ready) begin
        if (events.func)
          apply_control(events.action);
        else
          scaled_q.push_back(scale_event(events.event_kind, events.motion_value,
                                         events.sync_flag));
      end
    end
    pending = scaled_q.size();
  end

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the pointer motion scaler testbench: clock, reset, stimulus and verdict.
module tb_top;
  import pms_pkg::*;

  localparam logic FUNC_EVENT   = 1'b0;
  localparam logic FUNC_CONTROL = 1'b1;
  localparam int   RANDOM_ITEMS = 1850;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   burst_left;

  pms_in_if  ev_if ();
  pms_out_if res_if ();

  pointer_motion_scaler_unit dut (
    .clk     (clk),
    .rst     (rst),
    .events  (ev_if),
    .results (res_if)
  );

  pms_checker pms_check (
    .clk        (clk),
    .rst        (rst),
    .events     (ev_if),
    .results    (res_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic signed [15:0] random_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 16'(int'($urandom_range(0, 80)) - 40);
    if (roll < 65) return 16'(int'($urandom_range(0, 6000)) - 3000);
    if (roll < 90) return 16'($urandom);
    roll = $urandom_range(0, 3);
    if (roll == 0) return 16'sh8000;
    if (roll == 1) return 16'sh7fff;
    if (roll == 2) return 16'shffff;
    return 16'sh0001;
  endfunction

  // Holds the transaction until it is accepted, then idles for a random gap, or not at all inside a burst.
  task automatic send_item(input logic f, input logic [2:0] kind,
                           input logic signed [15:0] value, input logic sync,
                           input logic [2:0] act);
    int gap;
    ev_if.func         <= f;
    ev_if.event_kind   <= kind;
    ev_if.motion_value <= value;
    ev_if.sync_flag    <= sync;
    ev_if.action       <= act;
    ev_if.valid        <= 1'b1;
    @(posedge clk);
    while (!ev_if.ready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(20, 60);
      gap = pick_gap();
    end
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_event(input logic [2:0] kind, input logic signed [15:0] value,
                            input logic sync);
    send_item(FUNC_EVENT, kind, value, sync, 3'($urandom));
  endtask

  task automatic send_ctrl(input logic [2:0] act);
    send_item(FUNC_CONTROL, 3'($urandom), 16'($urandom), 1'($urandom), act);
  endtask

  task automatic run_random();
    int issued;
    int roll;
    logic [2:0] act;
    logic [2:0] kind;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        // Drive one level hard against a table end.
        act = 3'($urandom_range(ACT_MOUSE_UP, ACT_SCROLL_DOWN));
        repeat (9) send_ctrl(act);
        issued += 9;
      end else if (roll < 20) begin
        // Codes above the defined actions should leave the state untouched.
        if ($urandom_range(0, 19) == 0) act = 3'($urandom_range(6, 7));
        else act = 3'($urandom_range(ACT_INV_WHEEL, ACT_SCROLL_DOWN));
        send_ctrl(act);
        issued++;
      end else begin
        if ($urandom_range(0, 99) < 85) kind = 3'($urandom_range(KIND_REL_X, KIND_WHEEL));
        else kind = 3'($urandom_range(4, 7));
        send_event(kind, random_value(), $urandom_range(0, 9) < 3);
        issued++;
      end
    end
  endtask

  initial begin
    forever begin
      if ($urandom_range(0, 3) == 0) begin
        res_if.ready <= 1'b1;
        repeat ($urandom_range(20, 120)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
        res_if.ready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  initial begin
    rst                <= 1'b1;
    ev_if.valid        <= 1'b0;
    ev_if.func         <= FUNC_EVENT;
    ev_if.event_kind   <= KIND_REL_X;
    ev_if.motion_value <= '0;
    ev_if.sync_flag    <= 1'b0;
    ev_if.action       <= ACT_INV_WHEEL;
    burst_left = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Saturating results at the reset levels, then dropped and kept zeros, undefined kinds and actions.
    send_event(KIND_REL_X, 16'sh7fff, 1'b0);
    send_event(KIND_REL_Y, 16'sh8000, 1'b1);
    send_event(KIND_REL_X, 16'sh0000, 1'b0);
    send_event(KIND_REL_Y, 16'sh0001, 1'b0);
    send_event(KIND_HWHEEL, 16'sh0001, 1'b0);
    send_event(KIND_WHEEL, 16'shffff, 1'b1);
    send_event(3'd4, 16'sh0000, 1'b0);
    send_event(3'd5, 16'sh8000, 1'b0);
    send_event(3'd6, 16'sh3039, 1'b1);
    send_event(3'd7, 16'sh0000, 1'b0);
    send_ctrl(ACT_INV_WHEEL);
    send_ctrl(ACT_INV_HWHEEL);
    send_ctrl(3'd6);
    send_ctrl(3'd7);
    // Scroll level from its reset value to the top of the table and one step beyond.
    repeat (6) send_ctrl(ACT_SCROLL_UP);
    send_event(KIND_WHEEL, 16'sh8000, 1'b0);
    send_event(KIND_HWHEEL, 16'sh7fff, 1'b0);
    send_ctrl(ACT_SCROLL_DOWN);
    send_ctrl(ACT_MOUSE_DOWN);
    send_ctrl(ACT_MOUSE_UP);
    send_event(KIND_REL_X, 16'sh7fff, 1'b0);

    run_random();

    ev_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/pms_pkg.sv
hdl/pms_in_if.sv
hdl/pms_out_if.sv
hdl/pms_front.sv
hdl/pms_queue.sv
hdl/pms_back.sv
hdl/pointer_motion_scaler_unit.sv
bench/pms_checker.sv
bench/tb_top.sv
